[design/brb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and request codes of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DataW  = 8;
  localparam int AmtW   = 8;
  localparam int OccW   = 8;
  localparam int CfgW   = 9;
  localparam int AddrW  = 8;
  localparam int ReqW   = 3;

  localparam logic [ReqW-1:0] REQ_PUT   = 3'd0;
  localparam logic [ReqW-1:0] REQ_POP   = 3'd1;
  localparam logic [ReqW-1:0] REQ_PEEK  = 3'd2;
  localparam logic [ReqW-1:0] REQ_SKIP  = 3'd3;
  localparam logic [ReqW-1:0] REQ_CLEAR = 3'd4;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [DataW-1:0] data_in;
    logic [AmtW-1:0]  amount;
  } brb_in_t;

  typedef struct packed {
    logic             ok;
    logic [DataW-1:0] data_out;
    logic [OccW-1:0]  occupancy;
  } brb_out_t;

  // store access for one transfer
  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [DataW-1:0] wr_data;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } brb_mem_req_t;

  // result fields known before the store read
  typedef struct packed {
    logic            ok;
    logic            rd;
    logic [OccW-1:0] occupancy;
  } brb_res_t;

endpackage

[design/byte_ring_buffer_peek_skip_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_skip_top
// Circular byte FIFO with put, pop, peek, skip and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the in_* valid/ready channel, one result per request
//   goes out on the out_* channel: ok flag, byte read, occupancy after.
//   The cfg_* channel writes the ring length (clamped to 2..min(DEPTH,256));
//   a write also empties the buffer. Write it only while the block is idle.
//   Latency: a result is valid the cycle after its request transfer.
//   Throughput: one request per cycle unless the output stalls; pointers
//   update per request, the store has one write and one registered read port.
//   While the output waits (out_valid_o high, out_ready_i low) in_ready_o is
//   low; the result register and store read data hold.
//   Reset empties the buffer and sets the ring length to its maximum. Store
//   contents are not cleared; no entry is read before it is written.
// ----------------------------------------------------------------------------
module byte_ring_buffer_peek_skip_top #(
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  brb_pkg::brb_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output brb_pkg::brb_out_t        out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [brb_pkg::CfgW-1:0] cfg_data_i
);
  import brb_pkg::*;

  localparam int TOP = (DEPTH < 256) ? DEPTH : 256;
  localparam int AW  = (TOP > 1) ? $clog2(TOP) : 1;

  logic             accept;
  logic             cfg_we;
  brb_mem_req_t     mem_req;
  brb_res_t         res;
  logic [DataW-1:0] rdata;

  logic             out_valid_q;
  logic             ok_q;
  logic             rd_q;
  logic [OccW-1:0]  occ_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  brb_ctrl #(
    .TOP (TOP),
    .AW  (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .mem_req_o  (mem_req),
    .res_o      (res)
  );

  brb_mem #(
    .TOP (TOP),
    .AW  (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q  <= res.ok;
      rd_q  <= res.rd;
      occ_q <= res.occupancy;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_data_o.ok        = ok_q;
  assign out_data_o.data_out  = rd_q ? rdata : '0;
  assign out_data_o.occupancy = occ_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after request transfer");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.req_type == REQ_CLEAR && !cfg_valid_i
    |=> out_data_o.ok && out_data_o.occupancy == '0)
    else $error("clear left data");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.data_out == '0)
    else $error("refused request returned data");

endmodule

[design/brb_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_mem
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module brb_mem #(
  parameter int TOP = 256,
  parameter int AW  = 8
) (
  input  logic                     clk_i,
  input  brb_pkg::brb_mem_req_t    req_i,
  output logic [brb_pkg::DataW-1:0] rdata_o
);
  import brb_pkg::*;

  logic [DataW-1:0] store_q [TOP];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      store_q[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= store_q[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/brb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ctrl
// Pointer and length registers, request decode and next-pointer logic.
// ----------------------------------------------------------------------------
module brb_ctrl #(
  parameter int TOP = 256,
  parameter int AW  = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [brb_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     accept_i,
  input  brb_pkg::brb_in_t         item_i,
  output brb_pkg::brb_mem_req_t    mem_req_o,
  output brb_pkg::brb_res_t        res_o
);
  import brb_pkg::*;

  localparam int LW = $clog2(TOP + 1);
  localparam logic [CfgW-1:0] TopCfg = CfgW'(TOP);
  localparam logic [CfgW-1:0] MinCfg = CfgW'(2);

  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] rp_q, rp_d;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [AW-1:0] b,
                                        input logic [LW-1:0] l);
    logic [AW:0] sum;
    sum = {1'b0, p} + {1'b0, b};
    if (sum >= (AW+1)'(l)) begin
      sum = sum - (AW+1)'(l);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] occ_f(input logic [AW-1:0] w, input logic [AW-1:0] r,
                                          input logic [LW-1:0] l);
    logic [AW:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      d = d + (AW+1)'(l);
    end
    return d[AW-1:0];
  endfunction

  logic [AW-1:0]   occ;
  logic [AmtW-1:0] occ8;
  logic [AW-1:0]   wp_nxt;
  logic            peek_ok;
  logic [AW-1:0]   skip_n;
  logic [AW-1:0]   peek_idx;
  logic            ok;
  logic            rd;
  logic            wr;

  assign occ      = occ_f(wp_q, rp_q, len_q);
  assign occ8     = AmtW'(occ);
  assign wp_nxt   = adv(wp_q, AW'(1), len_q);
  assign peek_ok  = item_i.amount < occ8;
  assign skip_n   = (item_i.amount > occ8) ? occ : item_i.amount[AW-1:0];
  assign peek_idx = adv(rp_q, item_i.amount[AW-1:0], len_q);

  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    ok   = 1'b0;
    rd   = 1'b0;
    wr   = 1'b0;
    case (item_i.req_type)
      REQ_PUT: begin
        if (wp_nxt != rp_q) begin
          wr   = 1'b1;
          wp_d = wp_nxt;
          ok   = 1'b1;
        end
      end
      REQ_POP: begin
        if (occ != '0) begin
          rd   = 1'b1;
          rp_d = adv(rp_q, AW'(1), len_q);
          ok   = 1'b1;
        end
      end
      REQ_PEEK: begin
        if (peek_ok) begin
          rd = 1'b1;
          ok = 1'b1;
        end
      end
      REQ_SKIP: begin
        rp_d = adv(rp_q, skip_n, len_q);
        ok   = 1'b1;
      end
      REQ_CLEAR: begin
        wp_d = '0;
        rp_d = '0;
        ok   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cfg_data_i < MinCfg) begin
      len_d = LW'(2);
    end else if (cfg_data_i > TopCfg) begin
      len_d = LW'(TOP);
    end else begin
      len_d = cfg_data_i[LW-1:0];
    end
  end

  assign mem_req_o.wr_en   = accept_i & wr;
  assign mem_req_o.wr_addr = AddrW'(wp_q);
  assign mem_req_o.wr_data = item_i.data_in;
  assign mem_req_o.rd_en   = accept_i & rd;
  assign mem_req_o.rd_addr = (item_i.req_type == REQ_POP) ? AddrW'(rp_q) : AddrW'(peek_idx);

  assign res_o.ok        = ok;
  assign res_o.rd        = rd;
  assign res_o.occupancy = OccW'(occ_f(wp_d, rp_d, len_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LW'(TOP);
      wp_q  <= '0;
      rp_q  <= '0;
    end else if (cfg_we_i) begin
      len_q <= len_d;
      wp_q  <= '0;
      rp_q  <= '0;
    end else if (accept_i) begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

endmodule
